/* src/ihs_pkg.sv */
package ihs_pkg;

  localparam int unsigned CHAN_BITS            = 4;
  localparam int unsigned SAMPLE_BITS_DEFAULT  = 12;
  localparam int unsigned SENSOR_COUNT_DEFAULT = 3;

  localparam logic [CHAN_BITS-1:0] IR_BASE_RESET   = 4'd8;
  localparam logic [CHAN_BITS-1:0] HALL_BASE_RESET = 4'd11;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_EXPIRY = 2'd2
  } opcode_e;

  typedef enum logic [0:0] {
    REG_IR_BASE   = 1'b0,
    REG_HALL_BASE = 1'b1
  } cfg_reg_e;

endpackage

/* src/ihs_if.sv */
interface ihs_evt_if #(
  parameter int unsigned SAMPLE_BITS = ihs_pkg::SAMPLE_BITS_DEFAULT
);
  logic                           valid;
  logic                           ready;
  ihs_pkg::opcode_e               opcode;
  logic [ihs_pkg::CHAN_BITS-1:0]  sample_channel;
  logic [SAMPLE_BITS-1:0]         sample_value;

  modport source (output valid, opcode, sample_channel, sample_value, input ready);
  modport sink   (input valid, opcode, sample_channel, sample_value, output ready);
endinterface

interface ihs_res_if #(
  parameter int unsigned SAMPLE_BITS  = ihs_pkg::SAMPLE_BITS_DEFAULT,
  parameter int unsigned SENSOR_COUNT = ihs_pkg::SENSOR_COUNT_DEFAULT
);
  localparam int unsigned IDX_BITS = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  logic                           valid;
  logic                           ready;
  logic                           start_conversion;
  logic [ihs_pkg::CHAN_BITS-1:0]  conversion_channel;
  logic [SENSOR_COUNT-1:0]        led_mask;
  logic                           pulse_timer_start;
  logic [IDX_BITS-1:0]            sensor_index;
  logic                           hall_valid;
  logic [SAMPLE_BITS-1:0]         hall_value;
  logic                           ir_valid;
  logic [SAMPLE_BITS-1:0]         ambient_value;
  logic [SAMPLE_BITS-1:0]         reflected_value;
  logic signed [SAMPLE_BITS:0]    delta_value;
  logic                           scan_done;

  modport source (
    output valid, start_conversion, conversion_channel, led_mask, pulse_timer_start,
           sensor_index, hall_valid, hall_value, ir_valid, ambient_value,
           reflected_value, delta_value, scan_done,
    input  ready
  );
  modport sink (
    input  valid, start_conversion, conversion_channel, led_mask, pulse_timer_start,
           sensor_index, hall_valid, hall_value, ir_valid, ambient_value,
           reflected_value, delta_value, scan_done,
    output ready
  );
endinterface

interface ihs_cfg_if;
  logic                           valid;
  logic                           ready;
  ihs_pkg::cfg_reg_e              index;
  logic [ihs_pkg::CHAN_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/ir_hall_scan_sequencer.sv */
// Sequences IR proximity and Hall readout over SENSOR_COUNT sensors. Every accepted event
// (period tick, ADC result or pulse-timer expiry) produces exactly one result transaction,
// registered in the cycle after acceptance; a new event can be accepted in every cycle as long
// as the result register is free or is being taken in the same cycle. Configuration writes
// take effect at once and are always accepted.
module ir_hall_scan_sequencer #(
  parameter int unsigned SAMPLE_BITS  = ihs_pkg::SAMPLE_BITS_DEFAULT,
  parameter int unsigned SENSOR_COUNT = ihs_pkg::SENSOR_COUNT_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ihs_cfg_if.sink       cfg_i,
  ihs_evt_if.sink       evt_i,
  ihs_res_if.source     res_o
);

  localparam int unsigned IDX_BITS = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned CB       = ihs_pkg::CHAN_BITS;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SENSOR_COUNT - 1);

  logic [CB-1:0]           ir_base_q, hall_base_q;
  logic [IDX_BITS-1:0]     idx_q, idx_d;
  logic                    hall_phase_q, hall_phase_d;
  logic [CB-1:0]           pending_q, pending_d;
  logic [SAMPLE_BITS-1:0]  ambient_q, ambient_d;
  logic [SENSOR_COUNT-1:0] emitter_q, emitter_d;

  logic                    accept;
  logic                    res_valid_q;

  logic                    start_d, pulse_d, hall_v_d, ir_v_d, done_d;
  logic [CB-1:0]           chan_d;
  logic [IDX_BITS-1:0]     rep_idx_d;
  logic [SAMPLE_BITS-1:0]  hall_val_d, amb_out_d, ref_out_d;
  logic signed [SAMPLE_BITS:0] delta_d;

  logic [CB-1:0]           ir_chan, ir_chan_next, hall_chan;
  logic [SENSOR_COUNT-1:0] idx_bit;

  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign accept      = evt_i.valid && evt_i.ready;

  assign ir_chan      = CB'(ir_base_q + CB'(idx_q));
  assign ir_chan_next = CB'(ir_base_q + CB'(idx_q) + CB'(1));
  assign hall_chan    = CB'(hall_base_q + CB'(idx_q));
  assign idx_bit      = SENSOR_COUNT'(1) << idx_q;

  always_comb begin
    idx_d        = idx_q;
    hall_phase_d = hall_phase_q;
    pending_d    = pending_q;
    ambient_d    = ambient_q;
    emitter_d    = emitter_q;
    start_d      = 1'b0;
    chan_d       = '0;
    pulse_d      = 1'b0;
    rep_idx_d    = idx_q;
    hall_v_d     = 1'b0;
    hall_val_d   = '0;
    ir_v_d       = 1'b0;
    amb_out_d    = '0;
    ref_out_d    = '0;
    delta_d      = '0;
    done_d       = 1'b0;
    case (evt_i.opcode)
      ihs_pkg::OP_TICK: begin
        idx_d        = '0;
        hall_phase_d = 1'b0;
        rep_idx_d    = '0;
        start_d      = 1'b1;
        chan_d       = ir_base_q;
      end
      ihs_pkg::OP_SAMPLE: begin
        if (!hall_phase_q) begin
          ambient_d    = evt_i.sample_value;
          start_d      = 1'b1;
          chan_d       = hall_chan;
          pending_d    = ir_chan;
          emitter_d    = emitter_q | idx_bit;
          pulse_d      = 1'b1;
          hall_phase_d = 1'b1;
        end else if (evt_i.sample_channel == hall_chan) begin
          hall_v_d   = 1'b1;
          hall_val_d = evt_i.sample_value;
        end else begin
          emitter_d    = emitter_q & ~idx_bit;
          ir_v_d       = 1'b1;
          amb_out_d    = ambient_q;
          ref_out_d    = evt_i.sample_value;
          delta_d      = $signed({1'b0, evt_i.sample_value}) - $signed({1'b0, ambient_q});
          hall_phase_d = 1'b0;
          if (idx_q != LAST_IDX) begin
            idx_d   = IDX_BITS'(idx_q + IDX_BITS'(1));
            start_d = 1'b1;
            chan_d  = ir_chan_next;
          end else begin
            idx_d  = '0;
            done_d = 1'b1;
          end
        end
      end
      ihs_pkg::OP_EXPIRY: begin
        start_d = 1'b1;
        chan_d  = pending_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_base_q    <= ihs_pkg::IR_BASE_RESET;
      hall_base_q  <= ihs_pkg::HALL_BASE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ihs_pkg::REG_IR_BASE:   ir_base_q   <= cfg_i.data;
        ihs_pkg::REG_HALL_BASE: hall_base_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      hall_phase_q <= 1'b0;
      pending_q    <= '0;
      ambient_q    <= '0;
      emitter_q    <= '0;
    end else if (accept) begin
      idx_q        <= idx_d;
      hall_phase_q <= hall_phase_d;
      pending_q    <= pending_d;
      ambient_q    <= ambient_d;
      emitter_q    <= emitter_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_o.start_conversion   <= start_d;
      res_o.conversion_channel <= chan_d;
      res_o.led_mask           <= emitter_d;
      res_o.pulse_timer_start  <= pulse_d;
      res_o.sensor_index       <= rep_idx_d;
      res_o.hall_valid         <= hall_v_d;
      res_o.hall_value         <= hall_val_d;
      res_o.ir_valid           <= ir_v_d;
      res_o.ambient_value      <= amb_out_d;
      res_o.reflected_value    <= ref_out_d;
      res_o.delta_value        <= delta_d;
      res_o.scan_done          <= done_d;
    end
  end

  assign res_o.valid = res_valid_q;

endmodule

/* test/ir_hall_scan_sequencer_tb.sv */
`timescale 1ns / 100ps

module ir_hall_scan_sequencer_tb;

  localparam int CLK_PERIOD  = 10;
  localparam int SENSORS     = ihs_pkg::SENSOR_COUNT_DEFAULT;
  localparam int CHUNK_ITEMS = 60;
  localparam int CHUNKS      = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_OFF    = 80;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    ihs_pkg::opcode_e op;
    logic [3:0]       chan;
    logic [11:0]      value;
  } scan_event_t;

  typedef struct {
    logic               start_conv;
    logic [3:0]         channel;
    logic [2:0]         leds;
    logic               pulse_start;
    logic [1:0]         sensor_idx;
    logic               hall_valid;
    logic [11:0]        hall_value;
    logic               ir_valid;
    logic [11:0]        ambient;
    logic [11:0]        reflected;
    logic signed [12:0] delta;
    logic               scan_done;
  } scan_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               offer_valid = 1'b0;
  scan_event_t        offer = '{ihs_pkg::OP_TICK, 4'd0, 12'd0};
  logic               taking_results = 1'b0;
  logic               cfg_valid = 1'b0;
  ihs_pkg::cfg_reg_e  cfg_index = ihs_pkg::REG_IR_BASE;
  logic [3:0]         cfg_data = 4'd0;

  logic hold_results = 1'b0;
  logic quiet_tail = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;

  scan_event_t  pending_events[$];
  scan_result_t expected_scan_results[$];

  logic [3:0]  ir_base = ihs_pkg::IR_BASE_RESET;
  logic [3:0]  hall_base = ihs_pkg::HALL_BASE_RESET;
  logic [2:0]  scan_phase = '0;
  logic [3:0]  pending_chan = '0;
  logic [11:0] ambient_level = '0;
  logic [2:0]  emitters = '0;

  ihs_cfg_if cfg_bus ();
  ihs_evt_if evt_bus ();
  ihs_res_if res_bus ();

  assign cfg_bus.valid          = cfg_valid;
  assign cfg_bus.index          = cfg_index;
  assign cfg_bus.data           = cfg_data;
  assign evt_bus.valid          = offer_valid;
  assign evt_bus.opcode         = offer.op;
  assign evt_bus.sample_channel = offer.chan;
  assign evt_bus.sample_value   = offer.value;
  assign res_bus.ready          = taking_results;

  ir_hall_scan_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .evt_i  (evt_bus),
    .res_o  (res_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic scan_result_t predict_scan_step(input scan_event_t ev);
    scan_result_t r;
    logic [1:0]   sensor;
    r = '{default: '0};
    if (scan_phase >= 3'(2 * SENSORS)) scan_phase = '0;
    sensor = scan_phase[2:1];
    case (ev.op)
      ihs_pkg::OP_TICK: begin
        scan_phase = '0;
        sensor = '0;
        r.start_conv = 1'b1;
        r.channel = ir_base;
      end
      ihs_pkg::OP_SAMPLE: begin
        if (!scan_phase[0]) begin
          ambient_level = ev.value;
          r.start_conv = 1'b1;
          r.channel = hall_base + 4'(sensor);
          pending_chan = ir_base + 4'(sensor);
          emitters[sensor] = 1'b1;
          r.pulse_start = 1'b1;
          scan_phase = {sensor, 1'b1};
        end else if (ev.chan == 4'(hall_base + 4'(sensor))) begin
          r.hall_valid = 1'b1;
          r.hall_value = ev.value;
        end else begin
          emitters[sensor] = 1'b0;
          r.ir_valid = 1'b1;
          r.ambient = ambient_level;
          r.reflected = ev.value;
          r.delta = {1'b0, ev.value} - {1'b0, ambient_level};
          if (sensor < 2'(SENSORS - 1)) begin
            scan_phase = {sensor + 2'd1, 1'b0};
            r.start_conv = 1'b1;
            r.channel = ir_base + 4'(sensor) + 4'd1;
          end else begin
            scan_phase = '0;
            r.scan_done = 1'b1;
          end
        end
      end
      ihs_pkg::OP_EXPIRY: begin
        r.start_conv = 1'b1;
        r.channel = pending_chan;
      end
      default: ;
    endcase
    r.leds = emitters;
    r.sensor_idx = sensor;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_result(input scan_result_t want);
    check_field("start_conversion", 16'(res_bus.start_conversion), 16'(want.start_conv));
    check_field("conversion_channel", 16'(res_bus.conversion_channel), 16'(want.channel));
    check_field("led_mask", 16'(res_bus.led_mask), 16'(want.leds));
    check_field("pulse_timer_start", 16'(res_bus.pulse_timer_start), 16'(want.pulse_start));
    check_field("sensor_index", 16'(res_bus.sensor_index), 16'(want.sensor_idx));
    check_field("hall_valid", 16'(res_bus.hall_valid), 16'(want.hall_valid));
    check_field("hall_value", 16'(res_bus.hall_value), 16'(want.hall_value));
    check_field("ir_valid", 16'(res_bus.ir_valid), 16'(want.ir_valid));
    check_field("ambient_value", 16'(res_bus.ambient_value), 16'(want.ambient));
    check_field("reflected_value", 16'(res_bus.reflected_value), 16'(want.reflected));
    check_field("delta_value", 16'(res_bus.delta_value), 16'(want.delta));
    check_field("scan_done", 16'(res_bus.scan_done), 16'(want.scan_done));
  endtask

  task automatic queue_event(input ihs_pkg::opcode_e op, input logic [3:0] chan,
                             input logic [11:0] value);
    pending_events.push_back('{op, chan, value});
  endtask

  task automatic queue_noise();
    ihs_pkg::opcode_e op;
    op = ($urandom_range(0, 15) == 0) ? ihs_pkg::opcode_e'(OP_UNUSED)
                                      : ihs_pkg::opcode_e'($urandom_range(0, 2));
    queue_event(op, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
  endtask

  task automatic add_random_scan();
    logic [3:0] hall_chan;
    logic [3:0] refl_chan;
    if ($urandom_range(0, 9) != 0)
      queue_event(ihs_pkg::OP_TICK, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
    for (int s = 0; s < SENSORS; s++) begin
      hall_chan = hall_base + 4'(s);
      queue_event(ihs_pkg::OP_SAMPLE, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
      repeat ($urandom_range(0, 2))
        queue_event(ihs_pkg::OP_SAMPLE, hall_chan, 12'($urandom_range(0, 4095)));
      repeat ($urandom_range(0, 2))
        queue_event(ihs_pkg::OP_EXPIRY, 4'($urandom_range(0, 15)),
                    12'($urandom_range(0, 4095)));
      if ($urandom_range(0, 7) == 0) queue_noise();
      refl_chan = $urandom_range(0, 1) ? ir_base + 4'(s) : 4'($urandom_range(0, 15));
      if (refl_chan == hall_chan) refl_chan = hall_chan + 4'd1;
      queue_event(ihs_pkg::OP_SAMPLE, refl_chan, 12'($urandom_range(0, 4095)));
      if ($urandom_range(0, 19) == 0) break;
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || offer_valid || expected_scan_results.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apply_bases(input logic [3:0] ir, input logic [3:0] hall);
    cfg_valid <= 1'b1;
    cfg_index <= ihs_pkg::REG_IR_BASE;
    cfg_data  <= ir;
    do @(posedge clk_i); while (!cfg_bus.ready);
    ir_base = ir;
    cfg_index <= ihs_pkg::REG_HALL_BASE;
    cfg_data  <= hall;
    do @(posedge clk_i); while (!cfg_bus.ready);
    hall_base = hall;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      offer_valid <= 1'b0;
    end else begin
      if (offer_valid && evt_bus.ready) expected_scan_results.push_back(predict_scan_step(offer));
      if (!offer_valid || evt_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          offer_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 6);
          offer_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          offer <= pending_events.pop_front();
          offer_valid <= 1'b1;
        end else begin
          offer_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      taking_results <= 1'b0;
    end else begin
      if (res_bus.valid && taking_results) begin
        if (expected_scan_results.size() == 0) report_mismatch("result with no expectation");
        else check_result(expected_scan_results.pop_front());
      end
      if (hold_results) begin
        taking_results <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        taking_results <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 6);
        taking_results <= 1'b0;
      end else begin
        taking_results <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((offer_valid && evt_bus.ready) || (res_bus.valid && taking_results) ||
          (cfg_valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    scan_event_t directed[20];
    logic [3:0]  ir_pick;
    logic [3:0]  hall_pick;
    logic [3:0]  ir_table[4];
    logic [3:0]  hall_table[4];

    ir_table   = '{4'd0, 4'd13, 4'd0, 4'd13};
    hall_table = '{4'd13, 4'd0, 4'd0, 4'd13};

    // With the reset bases the IR channels are 8 to 10 and the Hall channels 11 to 13.
    directed = '{
      '{ihs_pkg::OP_TICK,   4'd0,  12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd0,  12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd11, 12'hfff},
      '{ihs_pkg::OP_EXPIRY, 4'd0,  12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd8,  12'hfff},
      '{ihs_pkg::OP_SAMPLE, 4'd9,  12'hfff},
      '{ihs_pkg::OP_EXPIRY, 4'd15, 12'hfff},
      '{ihs_pkg::OP_SAMPLE, 4'd12, 12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd9,  12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd10, 12'haaa},
      '{ihs_pkg::OP_SAMPLE, 4'd13, 12'h555},
      '{ihs_pkg::OP_EXPIRY, 4'd0,  12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd15, 12'h555},
      '{ihs_pkg::OP_SAMPLE, 4'd15, 12'h123},
      '{ihs_pkg::OP_EXPIRY, 4'd0,  12'd0},
      '{ihs_pkg::opcode_e'(OP_UNUSED), 4'd15, 12'hfff},
      '{ihs_pkg::OP_TICK,   4'd15, 12'hfff},
      '{ihs_pkg::OP_EXPIRY, 4'd0,  12'd0},
      '{ihs_pkg::OP_SAMPLE, 4'd0,  12'h800},
      '{ihs_pkg::OP_SAMPLE, 4'd7,  12'h7ff}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) pending_events.push_back(directed[i]);
    wait_drained();

    for (int n = 0; n < CHUNKS; n++) begin
      if (n < 4) begin
        ir_pick = ir_table[n];
        hall_pick = hall_table[n];
      end else begin
        ir_pick = 4'($urandom_range(0, 13));
        hall_pick = 4'($urandom_range(0, 13));
      end
      apply_bases(ir_pick, hall_pick);
      if (n == CHUNKS - 1) quiet_tail = 1'b1;
      while (pending_events.size() < CHUNK_ITEMS) add_random_scan();
      if (n == 2) begin
        // The results are held back while events keep coming, so the block has to stall.
        hold_results <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_results <= 1'b0;
      end
      wait_drained();
    end

    repeat (5) @(posedge clk_i);
    if (expected_scan_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_scan_results.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ihs_pkg.sv
src/ihs_if.sv
src/ir_hall_scan_sequencer.sv
test/ir_hall_scan_sequencer_tb.sv
